// ----- sv/two_axis_servo_speed_stepper_core_assert.svh -----
// assertion helpers shared by the stepper core
`ifndef TWO_AXIS_SERVO_SPEED_STEPPER_CORE_ASSERT_SVH
`define TWO_AXIS_SERVO_SPEED_STEPPER_CORE_ASSERT_SVH

// same-cycle implication, checked on every rising clock edge outside reset
`define TASS_ASSERT_IMP(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("stepper core assertion failed");

// next-cycle implication
`define TASS_ASSERT_NXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("stepper core assertion failed");

`endif

// ----- sv/tass_pkg.sv -----
package tass_pkg;

   // field widths
   localparam int TIME_BITS      = 32;
   localparam int IN_TIME_BITS   = 32;
   localparam int POS_BITS       = 8;
   localparam int SPEED_BITS     = 8;
   localparam int MAG_BITS       = 7;
   localparam int RATE_BITS      = 16;
   localparam int CSR_INDEX_BITS = 4;
   localparam int CSR_DATA_BITS  = 16;

   // divider: quotient bits retired per cycle
   localparam int DIV_RADIX_BITS = 2;
   localparam int DIV_STEPS      = RATE_BITS / DIV_RADIX_BITS;
   localparam int DIV_CNT_BITS   = $clog2(DIV_STEPS);

   // register indexes
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MIN_POSITION  = 4'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MAX_POSITION  = 4'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MAX_SPEED     = 4'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_RATE_CONSTANT = 4'd3;

   // reset values
   localparam logic [POS_BITS-1:0]  MIN_POS_RESET   = 8'd0;
   localparam logic [POS_BITS-1:0]  MAX_POS_RESET   = 8'd180;
   localparam logic [MAG_BITS-1:0]  MAX_SPEED_RESET = 7'd100;
   localparam logic [RATE_BITS-1:0] RATE_RESET      = 16'd1000;
   localparam logic [POS_BITS-1:0]  ANGLE_RESET     = 8'd90;

   // divider request and response
   typedef struct packed {
      logic                 start;
      logic [RATE_BITS-1:0] dividend;
      logic [MAG_BITS-1:0]  divisor;
   } div_req_type;

   typedef struct packed {
      logic                 done;
      logic [RATE_BITS-1:0] quotient;
   } div_rsp_type;

endpackage

// ----- sv/tass_if.sv -----
// tick channel
interface tass_req_if;
   logic                                  valid;
   logic                                  ready;
   logic [tass_pkg::IN_TIME_BITS-1:0]     time_ms;
   logic signed [tass_pkg::SPEED_BITS-1:0] speed_x;
   logic signed [tass_pkg::SPEED_BITS-1:0] speed_y;

   modport source (output valid, time_ms, speed_x, speed_y, input ready);
   modport sink (input valid, time_ms, speed_x, speed_y, output ready);
endinterface

// position channel
interface tass_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [tass_pkg::POS_BITS-1:0] position_x;
   logic [tass_pkg::POS_BITS-1:0] position_y;
   logic                          stepped_x;
   logic                          stepped_y;

   modport source (output valid, position_x, position_y, stepped_x, stepped_y, input ready);
   modport sink (input valid, position_x, position_y, stepped_x, stepped_y, output ready);
endinterface

// ----- sv/tass_div.sv -----
module tass_div (
   input  logic                  clock,
   input  logic                  reset,
   input  tass_pkg::div_req_type div_req,
   output tass_pkg::div_rsp_type div_rsp
);

   logic                                 running_ff, running_in;
   logic                                 done_ff, done_in;
   logic [tass_pkg::DIV_CNT_BITS-1:0]    cnt_ff, cnt_in;
   logic [tass_pkg::MAG_BITS-1:0]        rem_ff, rem_in;
   logic [tass_pkg::RATE_BITS-1:0]       quo_ff, quo_in;
   logic [tass_pkg::MAG_BITS-1:0]        divisor_ff, divisor_in;
   logic [tass_pkg::MAG_BITS-1:0]        rem_step;
   logic [tass_pkg::RATE_BITS-1:0]       quo_step;
   logic [tass_pkg::MAG_BITS:0]          trial;
   logic                                 qbit;

   // restoring division, DIV_RADIX_BITS quotient bits per cycle
   always_comb begin
      rem_step = rem_ff;
      quo_step = quo_ff;
      trial    = '0;
      qbit     = 1'b0;
      for (int i = 0; i < tass_pkg::DIV_RADIX_BITS; i++) begin
         trial    = {rem_step, quo_step[tass_pkg::RATE_BITS-1]};
         qbit     = (trial >= {1'b0, divisor_ff});
         rem_step = qbit ? tass_pkg::MAG_BITS'(trial - {1'b0, divisor_ff})
                         : trial[tass_pkg::MAG_BITS-1:0];
         quo_step = {quo_step[tass_pkg::RATE_BITS-2:0], qbit};
      end
   end

   // sequencing of the iterations
   always_comb begin
      running_in = running_ff;
      done_in    = 1'b0;
      cnt_in     = cnt_ff;
      rem_in     = rem_ff;
      quo_in     = quo_ff;
      divisor_in = divisor_ff;
      if (div_req.start) begin
         running_in = 1'b1;
         cnt_in     = '0;
         rem_in     = '0;
         quo_in     = div_req.dividend;
         divisor_in = div_req.divisor;
      end else if (running_ff) begin
         rem_in = rem_step;
         quo_in = quo_step;
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == tass_pkg::DIV_CNT_BITS'(tass_pkg::DIV_STEPS - 1)) begin
            running_in = 1'b0;
            done_in    = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         running_ff <= 1'b0;
         done_ff    <= 1'b0;
         cnt_ff     <= '0;
      end else begin
         running_ff <= running_in;
         done_ff    <= done_in;
         cnt_ff     <= cnt_in;
      end
      rem_ff     <= rem_in;
      quo_ff     <= quo_in;
      divisor_ff <= divisor_in;
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quo_ff;

endmodule

// ----- sv/two_axis_servo_speed_stepper_core.sv -----
// Two-axis servo speed stepper.
// The req_chan channel takes one tick transaction: millisecond time and a signed
// speed per axis. The rsp_chan channel returns one transaction per tick with
// both servo angles and a step flag for each axis. The user must write the
// registers over the csr_ port (index, data, write enable) only while no tick
// is in flight; the block itself does not enforce this. A tick is handled
// one axis after the other. An axis with nonzero speed runs the shared
// divider (rate constant over speed magnitude), which retires two quotient
// bits a cycle for the 16-bit quotient; an axis at zero speed skips it.
// Each axis passes through the setup, divide (when needed) and position
// update states, then the response is offered. One tick is in flight at a
// time: a new tick can be accepted the cycle after the response is taken.
// While rsp_chan is stalled the response holds and req_chan stays not
// ready. Synchronous reset restores the register defaults, both angles to
// 90 degrees and both last step times to zero.
module two_axis_servo_speed_stepper_core (
   input  logic                                 clock,
   input  logic                                 reset,
   tass_req_if.sink                             req_chan,
   tass_rsp_if.source                           rsp_chan,
   input  logic                                 csr_we,
   input  logic [tass_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [tass_pkg::CSR_DATA_BITS-1:0]   csr_wdata
);

   `include "two_axis_servo_speed_stepper_core_assert.svh"

   typedef enum logic [4:0] {
      S_IDLE = 5'b00001,
      S_PREP = 5'b00010,
      S_DIV  = 5'b00100,
      S_UPD  = 5'b01000,
      S_OUT  = 5'b10000
   } state_type;

   state_type                              state_ff, state_in;
   logic [tass_pkg::POS_BITS-1:0]          min_pos_ff, min_pos_in;
   logic [tass_pkg::POS_BITS-1:0]          max_pos_ff, max_pos_in;
   logic [tass_pkg::MAG_BITS-1:0]          max_speed_ff, max_speed_in;
   logic [tass_pkg::RATE_BITS-1:0]         rate_ff, rate_in;
   logic [tass_pkg::POS_BITS-1:0]          angle_x_ff, angle_x_in;
   logic [tass_pkg::POS_BITS-1:0]          angle_y_ff, angle_y_in;
   logic [tass_pkg::TIME_BITS-1:0]         last_x_ff, last_x_in;
   logic [tass_pkg::TIME_BITS-1:0]         last_y_ff, last_y_in;
   logic [tass_pkg::TIME_BITS-1:0]         now_ff, now_in;
   logic signed [tass_pkg::SPEED_BITS-1:0] speed_x_ff, speed_x_in;
   logic signed [tass_pkg::SPEED_BITS-1:0] speed_y_ff, speed_y_in;
   logic                                   axis_ff, axis_in;
   logic [tass_pkg::RATE_BITS-1:0]         period_ff, period_in;
   logic                                   stepped_x_ff, stepped_x_in;
   logic                                   stepped_y_ff, stepped_y_in;

   logic signed [tass_pkg::SPEED_BITS-1:0] cur_speed;
   logic [tass_pkg::SPEED_BITS-1:0]        neg_speed;
   logic [tass_pkg::MAG_BITS-1:0]          cur_mag;
   logic [tass_pkg::POS_BITS-1:0]          cur_angle;
   logic [tass_pkg::TIME_BITS-1:0]         cur_last;
   logic [tass_pkg::TIME_BITS-1:0]         elapsed;
   logic                                   step_hit;
   logic signed [tass_pkg::POS_BITS+1:0]   moved;
   logic [tass_pkg::POS_BITS-1:0]          new_angle;
   logic [63:0]                            time_wide;
   logic                                   req_accept;

   tass_pkg::div_req_type                  div_req;
   tass_pkg::div_rsp_type                  div_rsp;

   // clamp a commanded speed to plus or minus the limit
   function automatic logic signed [tass_pkg::SPEED_BITS-1:0] clamp_speed(
      input logic signed [tass_pkg::SPEED_BITS-1:0] s,
      input logic [tass_pkg::MAG_BITS-1:0]          lim
   );
      logic signed [tass_pkg::SPEED_BITS:0] s9;
      logic signed [tass_pkg::SPEED_BITS:0] l9;
      logic signed [tass_pkg::SPEED_BITS:0] r9;
      s9 = {s[tass_pkg::SPEED_BITS-1], s};
      l9 = {2'b00, lim};
      if (s9 < -l9) begin
         r9 = -l9;
      end else if (s9 > l9) begin
         r9 = l9;
      end else begin
         r9 = s9;
      end
      return r9[tass_pkg::SPEED_BITS-1:0];
   endfunction

   // clamp a moved angle into the position window
   function automatic logic [tass_pkg::POS_BITS-1:0] clamp_pos(
      input logic signed [tass_pkg::POS_BITS+1:0] p,
      input logic [tass_pkg::POS_BITS-1:0]        lo,
      input logic [tass_pkg::POS_BITS-1:0]        hi
   );
      logic signed [tass_pkg::POS_BITS+1:0] lo10;
      logic signed [tass_pkg::POS_BITS+1:0] hi10;
      lo10 = {2'b00, lo};
      hi10 = {2'b00, hi};
      if (p < lo10) begin
         return lo;
      end else if (p > hi10) begin
         return hi;
      end
      return p[tass_pkg::POS_BITS-1:0];
   endfunction

   tass_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   // per-axis datapath, shared by both axes
   always_comb begin
      cur_speed = axis_ff ? speed_y_ff : speed_x_ff;
      cur_angle = axis_ff ? angle_y_ff : angle_x_ff;
      cur_last  = axis_ff ? last_y_ff : last_x_ff;
      neg_speed = tass_pkg::SPEED_BITS'(-cur_speed);
      cur_mag   = cur_speed[tass_pkg::SPEED_BITS-1] ? neg_speed[tass_pkg::MAG_BITS-1:0]
                                                    : cur_speed[tass_pkg::MAG_BITS-1:0];
      elapsed   = now_ff - cur_last;
      step_hit  = (cur_speed != '0) && (elapsed > tass_pkg::TIME_BITS'(period_ff));
      moved     = cur_speed[tass_pkg::SPEED_BITS-1] ? ({2'b00, cur_angle} - 10'sd1)
                                                    : ({2'b00, cur_angle} + 10'sd1);
      new_angle = clamp_pos(moved, min_pos_ff, max_pos_ff);
   end

   assign time_wide  = 64'(req_chan.time_ms);
   assign req_accept = req_chan.valid && req_chan.ready;

   // sequencer
   always_comb begin
      state_in     = state_ff;
      min_pos_in   = min_pos_ff;
      max_pos_in   = max_pos_ff;
      max_speed_in = max_speed_ff;
      rate_in      = rate_ff;
      angle_x_in   = angle_x_ff;
      angle_y_in   = angle_y_ff;
      last_x_in    = last_x_ff;
      last_y_in    = last_y_ff;
      now_in       = now_ff;
      speed_x_in   = speed_x_ff;
      speed_y_in   = speed_y_ff;
      axis_in      = axis_ff;
      period_in    = period_ff;
      stepped_x_in = stepped_x_ff;
      stepped_y_in = stepped_y_ff;
      div_req.start    = 1'b0;
      div_req.dividend = rate_ff;
      div_req.divisor  = cur_mag;

      // register writes
      if (csr_we) begin
         case (csr_index)
            tass_pkg::CSR_MIN_POSITION:  min_pos_in   = csr_wdata[tass_pkg::POS_BITS-1:0];
            tass_pkg::CSR_MAX_POSITION:  max_pos_in   = csr_wdata[tass_pkg::POS_BITS-1:0];
            tass_pkg::CSR_MAX_SPEED:     max_speed_in = csr_wdata[tass_pkg::MAG_BITS-1:0];
            tass_pkg::CSR_RATE_CONSTANT: rate_in      = csr_wdata[tass_pkg::RATE_BITS-1:0];
            default: ;
         endcase
      end

      case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               now_in     = time_wide[tass_pkg::TIME_BITS-1:0];
               speed_x_in = clamp_speed(req_chan.speed_x, max_speed_ff);
               speed_y_in = clamp_speed(req_chan.speed_y, max_speed_ff);
               axis_in    = 1'b0;
               state_in   = S_PREP;
            end
         end
         S_PREP: begin
            // zero speed skips the division
            if (cur_speed == '0) begin
               state_in = S_UPD;
            end else begin
               div_req.start = 1'b1;
               state_in      = S_DIV;
            end
         end
         S_DIV: begin
            if (div_rsp.done) begin
               period_in = div_rsp.quotient;
               state_in  = S_UPD;
            end
         end
         S_UPD: begin
            if (axis_ff) begin
               stepped_y_in = step_hit;
               if (step_hit) begin
                  angle_y_in = new_angle;
                  last_y_in  = now_ff;
               end
               state_in = S_OUT;
            end else begin
               stepped_x_in = step_hit;
               if (step_hit) begin
                  angle_x_in = new_angle;
                  last_x_in  = now_ff;
               end
               axis_in  = 1'b1;
               state_in = S_PREP;
            end
         end
         S_OUT: begin
            if (rsp_chan.ready) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         min_pos_ff   <= tass_pkg::MIN_POS_RESET;
         max_pos_ff   <= tass_pkg::MAX_POS_RESET;
         max_speed_ff <= tass_pkg::MAX_SPEED_RESET;
         rate_ff      <= tass_pkg::RATE_RESET;
         angle_x_ff   <= tass_pkg::ANGLE_RESET;
         angle_y_ff   <= tass_pkg::ANGLE_RESET;
         last_x_ff    <= '0;
         last_y_ff    <= '0;
         axis_ff      <= 1'b0;
      end else begin
         state_ff     <= state_in;
         min_pos_ff   <= min_pos_in;
         max_pos_ff   <= max_pos_in;
         max_speed_ff <= max_speed_in;
         rate_ff      <= rate_in;
         angle_x_ff   <= angle_x_in;
         angle_y_ff   <= angle_y_in;
         last_x_ff    <= last_x_in;
         last_y_ff    <= last_y_in;
         axis_ff      <= axis_in;
      end
      now_ff       <= now_in;
      speed_x_ff   <= speed_x_in;
      speed_y_ff   <= speed_y_in;
      period_ff    <= period_in;
      stepped_x_ff <= stepped_x_in;
      stepped_y_ff <= stepped_y_in;
   end

   // channel outputs
   assign req_chan.ready      = (state_ff == S_IDLE);
   assign rsp_chan.valid      = (state_ff == S_OUT);
   assign rsp_chan.position_x = angle_x_ff;
   assign rsp_chan.position_y = angle_y_ff;
   assign rsp_chan.stepped_x  = stepped_x_ff;
   assign rsp_chan.stepped_y  = stepped_y_ff;

   // checks
   `TASS_ASSERT_IMP(a_one_in_flight, req_chan.ready, !rsp_chan.valid)
   `TASS_ASSERT_IMP(a_div_done_in_wait, div_rsp.done, state_ff == S_DIV)
   `TASS_ASSERT_NXT(a_accept_starts_x, req_accept, (state_ff == S_PREP) && !axis_ff)
   `TASS_ASSERT_IMP(a_step_in_window, rsp_chan.valid && rsp_chan.stepped_x,
      ((rsp_chan.position_x >= min_pos_ff) && (rsp_chan.position_x <= max_pos_ff)) ||
      (rsp_chan.position_x == min_pos_ff) || (rsp_chan.position_x == max_pos_ff))

endmodule

// ----- dv/testbench.sv -----
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import tass_pkg::*;

   // one position transaction as it leaves the block
   typedef struct packed {
      logic [POS_BITS-1:0] position_x;
      logic [POS_BITS-1:0] position_y;
      logic                stepped_x;
      logic                stepped_y;
   } servo_out_t;

   // directed plan: register writes, ticks with a typed answer, ticks left to the predictor
   typedef enum logic [1:0] {ROW_TICK, ROW_TYPED, ROW_CSR} row_kind_t;

   typedef struct packed {
      row_kind_t                  kind;
      logic [CSR_INDEX_BITS-1:0]  index;
      logic [31:0]                value;
      logic signed [SPEED_BITS-1:0] speed_x;
      logic signed [SPEED_BITS-1:0] speed_y;
      servo_out_t                 typed;
   } plan_row_t;

   localparam servo_out_t NO_ANSWER = '0;
   localparam int PLAN_ROWS = 38;
   localparam int PHASES = 8;
   localparam int PHASE_TICKS = 250;
   localparam int MAX_REPORTS = 10;

   // 8'sh80 is the most negative speed
   localparam plan_row_t DIRECTED_PLAN [PLAN_ROWS] = '{
      // after reset, no motion
      '{ROW_TYPED, '0, 32'd0,       8'sd0,   8'sd0,   '{8'd90,  8'd90,  1'b0, 1'b0}},
      '{ROW_TYPED, '0, 32'd0,       8'sd100, -8'sd100, '{8'd90,  8'd90,  1'b0, 1'b0}},
      // period 10: step only once elapsed exceeds it
      '{ROW_TYPED, '0, 32'd11,      8'sd100, -8'sd100, '{8'd91,  8'd89,  1'b1, 1'b1}},
      '{ROW_TYPED, '0, 32'd21,      8'sd127, 8'sh80,  '{8'd91,  8'd89,  1'b0, 1'b0}},
      '{ROW_TYPED, '0, 32'd22,      8'sd100, -8'sd100, '{8'd92,  8'd88,  1'b1, 1'b1}},
      // time wraps around
      '{ROW_TYPED, '0, 32'hFFFF_FFFF, 8'sd1, -8'sd1,   '{8'd93,  8'd87,  1'b1, 1'b1}},
      '{ROW_TYPED, '0, 32'd5,       8'sh80,  8'sd127, '{8'd93,  8'd87,  1'b0, 1'b0}},
      '{ROW_TYPED, '0, 32'd16,      -8'sd100, 8'sd100, '{8'd92,  8'd88,  1'b1, 1'b1}},
      // minimum above maximum, angles outside the window
      '{ROW_CSR, CSR_MIN_POSITION, 32'd100, 8'sd0, 8'sd0, NO_ANSWER},
      '{ROW_CSR, CSR_MAX_POSITION, 32'd95,  8'sd0, 8'sd0, NO_ANSWER},
      '{ROW_TYPED, '0, 32'h1000,    8'sd1,   8'sd1,   '{8'd100, 8'd100, 1'b1, 1'b1}},
      '{ROW_TYPED, '0, 32'h2000,    8'sd1,   -8'sd1,  '{8'd95,  8'd100, 1'b1, 1'b1}},
      // zero rate constant: any nonzero elapsed time steps
      '{ROW_CSR, CSR_MIN_POSITION,  32'd0,   8'sd0, 8'sd0, NO_ANSWER},
      '{ROW_CSR, CSR_MAX_POSITION,  32'd255, 8'sd0, 8'sd0, NO_ANSWER},
      '{ROW_CSR, CSR_MAX_SPEED,     32'd127, 8'sd0, 8'sd0, NO_ANSWER},
      '{ROW_CSR, CSR_RATE_CONSTANT, 32'd0,   8'sd0, 8'sd0, NO_ANSWER},
      '{ROW_TYPED, '0, 32'h2000,    8'sd5,   -8'sd5,  '{8'd95,  8'd100, 1'b0, 1'b0}},
      '{ROW_TYPED, '0, 32'h2001,    8'sd5,   -8'sd5,  '{8'd96,  8'd99,  1'b1, 1'b1}},
      // speed clamped to zero never steps
      '{ROW_CSR, CSR_MAX_SPEED,     32'd0,   8'sd0, 8'sd0, NO_ANSWER},
      '{ROW_TYPED, '0, 32'h9000,    8'sd127, 8'sh80,  '{8'd96,  8'd99,  1'b0, 1'b0}},
      // top of the angle range, largest rate constant
      '{ROW_CSR, CSR_MIN_POSITION,  32'd255,   8'sd0, 8'sd0, NO_ANSWER},
      '{ROW_CSR, CSR_MAX_POSITION,  32'd255,   8'sd0, 8'sd0, NO_ANSWER},
      '{ROW_CSR, CSR_MAX_SPEED,     32'd127,   8'sd0, 8'sd0, NO_ANSWER},
      '{ROW_CSR, CSR_RATE_CONSTANT, 32'd65535, 8'sd0, 8'sd0, NO_ANSWER},
      '{ROW_TYPED, '0, 32'h10_0000, 8'sd127, 8'sh80,  '{8'd255, 8'd255, 1'b1, 1'b1}},
      '{ROW_TYPED, '0, 32'h10_0204, 8'sd127, 8'sh80,  '{8'd255, 8'd255, 1'b0, 1'b0}},
      '{ROW_TYPED, '0, 32'h10_0205, 8'sd127, 8'sh80,  '{8'd255, 8'd255, 1'b1, 1'b1}},
      // bottom of the angle range
      '{ROW_CSR, CSR_MIN_POSITION,  32'd0, 8'sd0, 8'sd0, NO_ANSWER},
      '{ROW_CSR, CSR_MAX_POSITION,  32'd0, 8'sd0, 8'sd0, NO_ANSWER},
      '{ROW_TYPED, '0, 32'h20_0000, -8'sd1,  8'sd1,   '{8'd0,   8'd0,   1'b1, 1'b1}},
      '{ROW_TYPED, '0, 32'h30_0000, -8'sd1,  -8'sd1,  '{8'd0,   8'd0,   1'b1, 1'b1}},
      // back to a normal window, angles below it until they step
      '{ROW_CSR, CSR_MIN_POSITION,  32'd10,   8'sd0, 8'sd0, NO_ANSWER},
      '{ROW_CSR, CSR_MAX_POSITION,  32'd170,  8'sd0, 8'sd0, NO_ANSWER},
      '{ROW_CSR, CSR_MAX_SPEED,     32'd100,  8'sd0, 8'sd0, NO_ANSWER},
      '{ROW_CSR, CSR_RATE_CONSTANT, 32'd1000, 8'sd0, 8'sd0, NO_ANSWER},
      '{ROW_TICK, '0, 32'h30_0000,  8'sd50,  -8'sd33, NO_ANSWER},
      '{ROW_TICK, '0, 32'h30_0100,  8'sd50,  -8'sd33, NO_ANSWER},
      '{ROW_TICK, '0, 32'h30_0110,  -8'sd7,  8'sd99,  NO_ANSWER}
   };

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic                      csr_we;
   logic [CSR_INDEX_BITS-1:0] csr_index;
   logic [CSR_DATA_BITS-1:0]  csr_wdata;

   tass_req_if req_chan ();
   tass_rsp_if rsp_chan ();

   two_axis_servo_speed_stepper_core i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // register mirror and servo state of the predictor
   logic [POS_BITS-1:0]  min_pos_cfg;
   logic [POS_BITS-1:0]  max_pos_cfg;
   logic [MAG_BITS-1:0]  max_speed_cfg;
   logic [RATE_BITS-1:0] rate_cfg;
   logic [POS_BITS-1:0]  angle_x_q;
   logic [POS_BITS-1:0]  angle_y_q;
   logic [TIME_BITS-1:0] last_step_x_q;
   logic [TIME_BITS-1:0] last_step_y_q;

   servo_out_t expected_positions [$];
   int mismatch_count = 0;
   int positions_seen = 0;
   bit req_gaps_on = 1'b1;
   bit rsp_gaps_on = 1'b1;

   initial begin
      forever #6 clock = ~clock;
   end

   // one axis: clamp speed, derive period, step and clamp angle
   function automatic bit step_axis(inout logic [POS_BITS-1:0] angle,
                                    inout logic [TIME_BITS-1:0] last_step,
                                    input logic [TIME_BITS-1:0] now_ms,
                                    input logic signed [SPEED_BITS-1:0] cmd);
      int limit;
      int speed;
      int period;
      int moved;
      logic [TIME_BITS-1:0] elapsed;
      limit = int'(max_speed_cfg);
      speed = int'(cmd);
      if (speed < -limit) speed = -limit;
      if (speed > limit) speed = limit;
      if (speed == 0) return 1'b0;
      period = int'(rate_cfg) / (speed < 0 ? -speed : speed);
      elapsed = now_ms - last_step;
      if (elapsed <= TIME_BITS'(period)) return 1'b0;
      moved = int'(angle) + (speed < 0 ? -1 : 1);
      if (moved < int'(min_pos_cfg)) moved = int'(min_pos_cfg);
      else if (moved > int'(max_pos_cfg)) moved = int'(max_pos_cfg);
      angle = moved[POS_BITS-1:0];
      last_step = now_ms;
      return 1'b1;
   endfunction

   function automatic servo_out_t advance_servos(logic [TIME_BITS-1:0] now_ms,
                                                 logic signed [SPEED_BITS-1:0] sx,
                                                 logic signed [SPEED_BITS-1:0] sy);
      servo_out_t r;
      r.stepped_x  = step_axis(angle_x_q, last_step_x_q, now_ms, sx);
      r.stepped_y  = step_axis(angle_y_q, last_step_y_q, now_ms, sy);
      r.position_x = angle_x_q;
      r.position_y = angle_y_q;
      return r;
   endfunction

   // register write on the csr port, mirrored in the predictor
   task automatic write_register(logic [CSR_INDEX_BITS-1:0] index,
                                 logic [CSR_DATA_BITS-1:0] data);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      @(negedge clock);
      csr_we <= 1'b0;
      case (index)
         CSR_MIN_POSITION:  min_pos_cfg   = data[POS_BITS-1:0];
         CSR_MAX_POSITION:  max_pos_cfg   = data[POS_BITS-1:0];
         CSR_MAX_SPEED:     max_speed_cfg = data[MAG_BITS-1:0];
         CSR_RATE_CONSTANT: rate_cfg      = data[RATE_BITS-1:0];
         default: ;
      endcase
   endtask

   // offer one tick transaction and record its expected positions once taken
   task automatic send_tick(logic [31:0] now_ms, logic signed [SPEED_BITS-1:0] sx,
                            logic signed [SPEED_BITS-1:0] sy, row_kind_t kind,
                            servo_out_t typed);
      int gap;
      servo_out_t predicted;
      gap = req_gaps_on ? $urandom_range(0, 16) : 0;
      if (gap > 0) begin
         @(negedge clock);
         req_chan.valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_chan.valid   <= 1'b1;
      req_chan.time_ms <= now_ms;
      req_chan.speed_x <= sx;
      req_chan.speed_y <= sy;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      predicted = advance_servos(now_ms, sx, sy);
      expected_positions.push_back(kind == ROW_TYPED ? typed : predicted);
   endtask

   // stop offering and wait until every position transaction is back
   task automatic drain_positions();
      @(negedge clock);
      req_chan.valid <= 1'b0;
      while (expected_positions.size() != 0) @(posedge clock);
   endtask

   // position receiver with random stalls and one long hold-off
   initial begin
      int hold;
      servo_out_t want;
      servo_out_t got;
      rsp_chan.ready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         hold = rsp_gaps_on ? $urandom_range(0, 16) : 0;
         if (positions_seen == 300) hold = 400;
         if (hold > 0) begin
            @(negedge clock);
            rsp_chan.ready <= 1'b0;
            repeat (hold - 1) @(negedge clock);
         end
         @(negedge clock);
         rsp_chan.ready <= 1'b1;
         @(posedge clock);
         while (!rsp_chan.valid) @(posedge clock);
         got = '{rsp_chan.position_x, rsp_chan.position_y,
                 rsp_chan.stepped_x, rsp_chan.stepped_y};
         positions_seen++;
         if (expected_positions.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
               $display("unexpected position transaction: x=%0d y=%0d step=%b%b",
                        got.position_x, got.position_y, got.stepped_x, got.stepped_y);
         end else begin
            want = expected_positions.pop_front();
            if (got !== want) begin
               mismatch_count++;
               if (mismatch_count <= MAX_REPORTS)
                  $display("position mismatch #%0d: expected x=%0d y=%0d step=%b%b, got x=%0d y=%0d step=%b%b",
                           positions_seen, want.position_x, want.position_y,
                           want.stepped_x, want.stepped_y, got.position_x,
                           got.position_y, got.stepped_x, got.stepped_y);
            end
         end
      end
   end

   // stimulus: directed plan, then random phases with fresh register settings
   initial begin
      logic [31:0] now_ms;
      logic signed [SPEED_BITS-1:0] sx;
      logic signed [SPEED_BITS-1:0] sy;
      logic [POS_BITS-1:0] lo;
      logic [POS_BITS-1:0] hi;
      logic [MAG_BITS-1:0] spd_limit;
      logic [RATE_BITS-1:0] rate;
      req_chan.valid   = 1'b0;
      req_chan.time_ms = '0;
      req_chan.speed_x = '0;
      req_chan.speed_y = '0;
      csr_we    = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      min_pos_cfg   = MIN_POS_RESET;
      max_pos_cfg   = MAX_POS_RESET;
      max_speed_cfg = MAX_SPEED_RESET;
      rate_cfg      = RATE_RESET;
      angle_x_q     = ANGLE_RESET;
      angle_y_q     = ANGLE_RESET;
      last_step_x_q = '0;
      last_step_y_q = '0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (DIRECTED_PLAN[i]) begin
         if (DIRECTED_PLAN[i].kind == ROW_CSR) begin
            drain_positions();
            write_register(DIRECTED_PLAN[i].index, DIRECTED_PLAN[i].value[CSR_DATA_BITS-1:0]);
         end else begin
            send_tick(DIRECTED_PLAN[i].value, DIRECTED_PLAN[i].speed_x,
                      DIRECTED_PLAN[i].speed_y, DIRECTED_PLAN[i].kind,
                      DIRECTED_PLAN[i].typed);
         end
      end

      now_ms = 32'h0030_0200;
      for (int phase = 0; phase < PHASES; phase++) begin
         // new register setting while idle
         drain_positions();
         case ($urandom_range(0, 3))
            0: begin lo = 8'($urandom_range(0, 20)); hi = 8'($urandom_range(160, 255)); end
            1: begin lo = 8'($urandom); hi = 8'($urandom); end
            2: begin lo = 8'($urandom_range(60, 120)); hi = lo + 8'($urandom_range(0, 10)); end
            default: begin lo = '0; hi = '1; end
         endcase
         spd_limit = (phase % 4 == 3) ? '1 : MAG_BITS'($urandom_range(0, 127));
         case ($urandom_range(0, 3))
            0: rate = RATE_BITS'($urandom_range(0, 60));
            1: rate = RATE_BITS'($urandom_range(200, 2500));
            2: rate = RATE_BITS'($urandom);
            default: rate = '1;
         endcase
         // upper bits carry noise that the block must drop
         write_register(CSR_MIN_POSITION, {8'($urandom), lo});
         write_register(CSR_MAX_POSITION, {8'($urandom), hi});
         write_register(CSR_MAX_SPEED, {9'($urandom), spd_limit});
         write_register(CSR_RATE_CONSTANT, rate);

         for (int item = 0; item < PHASE_TICKS; item++) begin
            if (item % 50 == 0) begin
               req_gaps_on = $urandom_range(0, 3) != 0;
               rsp_gaps_on = $urandom_range(0, 3) != 0;
            end
            // mostly a steady clock, sometimes a jump or an arbitrary time
            case ($urandom_range(0, 19))
               0: now_ms = $urandom;
               1, 2: now_ms = now_ms + $urandom_range(0, 300000);
               default: now_ms = now_ms + $urandom_range(0, 40);
            endcase
            sx = ($urandom_range(0, 3) == 0) ? SPEED_BITS'(int'($urandom_range(0, 10)) - 5)
                                             : SPEED_BITS'($urandom);
            sy = ($urandom_range(0, 3) == 0) ? SPEED_BITS'(int'($urandom_range(0, 10)) - 5)
                                             : SPEED_BITS'($urandom);
            send_tick(now_ms, sx, sy, ROW_TICK, NO_ANSWER);
         end
      end

      drain_positions();
      repeat (30) @(posedge clock);
      mismatch_count += expected_positions.size();
      if (mismatch_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

   // hard limit on the run
   initial begin
      #10_000_000;
      $display("Test completed with failures");
      $finish;
   end

endmodule
